/* rtl/core/efd_pkg.sv */
`timescale 1ns / 1ps

package efd_pkg;

    localparam int DEF_BUF_DEPTH = 64;

    localparam logic [7:0] START_BYTE = 8'hFE;
    localparam logic [7:0] END_BYTE   = 8'hFF;
    localparam logic [7:0] ESC_FE     = 8'hFC;
    localparam logic [7:0] ESC_FF     = 8'hFD;

    // header occupies buffer bytes 0..5, payload starts at byte 6
    localparam int HDR_LEN = 6;
    // length field counts the four port and address bytes
    localparam logic [7:0] LEN_BIAS = 8'd4;

    localparam int IDX_LEN  = 1;
    localparam int IDX_SRC  = 2;
    localparam int IDX_DST  = 3;
    localparam int IDX_ADLO = 4;
    localparam int IDX_ADHI = 5;

    // controller to datapath
    typedef struct packed {
        logic take_byte;   // byte inside a frame, buffer not full, not the end marker
        logic drop_frame;  // clear fill count and escape flag
        logic begin_emit;  // latch header fields and run length
        logic load_empty;  // load the single empty result
        logic load_data;   // load one payload result from ram read data
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_start;
        logic is_end;
        logic buf_full;
        logic run_empty;   // run length of the frame now in the buffer is zero
        logic out_free;    // output register can take a result this cycle
        logic run_last;    // current read index is the final payload byte
    } status_t;

endpackage

/* rtl/core/efd_if.sv */
`timescale 1ns / 1ps

interface efd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface efd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  src_port;
    logic [7:0]  dst_port;
    logic [15:0] node_addr;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        last;

    modport source (
        output valid, output src_port, output dst_port, output node_addr,
        output payload_byte, output payload_valid, output last,
        input ready
    );
    modport sink (
        input valid, input src_port, input dst_port, input node_addr,
        input payload_byte, input payload_valid, input last,
        output ready
    );
endinterface

/* rtl/core/escaped_frame_deframer_top.sv */
`timescale 1ns / 1ps

// Byte-stuffed frame deframer. Each request on rx is one received byte and is
// accepted while a frame is being hunted or collected; 0xFE opens a
// frame, 0xFE inside a frame escapes a following 0xFC or 0xFD, and a byte that
// arrives with the buffer full is dropped along with the frame. The closing 0xFF
// starts a readout that gives one result per payload byte (one empty result
// when the length is zero) with the ports and address of the frame. Readout
// walks the frame buffer: per payload result, a ram read state and then an
// output load state that waits for a free output register; rx is not ready
// meanwhile. The output register lets a result wait while the next is read.
module escaped_frame_deframer_top #(
    parameter int BUF_DEPTH = efd_pkg::DEF_BUF_DEPTH
) (
    input logic        clk,
    input logic        rst_n,
    efd_in_if.sink     rx,
    efd_out_if.source  res
);

    efd_pkg::cmd_t    cmd;
    efd_pkg::status_t status;

    efd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .status   (status),
        .cmd      (cmd)
    );

    efd_datapath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rx_byte       (rx.rx_byte),
        .out_ready     (res.ready),
        .out_valid     (res.valid),
        .src_port      (res.src_port),
        .dst_port      (res.dst_port),
        .node_addr     (res.node_addr),
        .payload_byte  (res.payload_byte),
        .payload_valid (res.payload_valid),
        .last          (res.last)
    );

endmodule

/* rtl/core/efd_ram.sv */
`timescale 1ns / 1ps

module efd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/efd_datapath.sv */
`timescale 1ns / 1ps

module efd_datapath #(
    parameter int BUF_DEPTH = efd_pkg::DEF_BUF_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  efd_pkg::cmd_t     cmd,
    output efd_pkg::status_t  status,
    input  logic [7:0]        rx_byte,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [7:0]        src_port,
    output logic [7:0]        dst_port,
    output logic [15:0]       node_addr,
    output logic [7:0]        payload_byte,
    output logic              payload_valid,
    output logic              last
);

    localparam int FW = $clog2(BUF_DEPTH + 1);
    localparam int AW = $clog2(BUF_DEPTH);

    logic [FW-1:0] fill_reg, fill_next;
    logic          esc_reg, esc_next;
    logic [7:0]    hdr_reg [efd_pkg::IDX_LEN:efd_pkg::IDX_ADHI];
    logic [FW-1:0] n_reg, k_reg;
    logic          out_valid_reg;
    logic [7:0]    run_src_reg, run_dst_reg;
    logic [15:0]   run_addr_reg;
    logic [7:0]    src_reg, dst_reg, pay_reg;
    logic [15:0]   addr_reg;
    logic          pv_reg, last_reg;

    logic          store;
    logic [7:0]    store_val;
    logic [7:0]    len_f, len_n;
    logic [FW-1:0] avail, n_next;
    logic [7:0]    ram_rdata;
    logic [AW-1:0] ram_raddr;

    function automatic logic [7:0] hdr_at(input logic [FW-1:0] fill, input logic [7:0] v,
                                          input int idx);
        logic [7:0] r;
        r = (fill > FW'(idx)) ? v : 8'h00;
        return r;
    endfunction

    // decode the incoming byte inside a frame
    always_comb
    begin
        store     = 1'b0;
        store_val = rx_byte;
        esc_next  = esc_reg;
        fill_next = fill_reg;
        if (cmd.take_byte)
        begin
            case (rx_byte)
                efd_pkg::ESC_FE:
                begin
                    store     = 1'b1;
                    store_val = esc_reg ? efd_pkg::START_BYTE : efd_pkg::ESC_FE;
                    esc_next  = 1'b0;
                end
                efd_pkg::ESC_FF:
                begin
                    store     = 1'b1;
                    store_val = esc_reg ? efd_pkg::END_BYTE : efd_pkg::ESC_FF;
                    esc_next  = 1'b0;
                end
                efd_pkg::START_BYTE:
                begin
                    esc_next = 1'b1;
                end
                default:
                begin
                    store = 1'b1;
                end
            endcase
            if (store)
            begin
                fill_next = fill_reg + FW'(1);
            end
        end
        if (cmd.drop_frame)
        begin
            esc_next  = 1'b0;
            fill_next = '0;
        end
    end

    // payload run length, clamped to what was received
    always_comb
    begin
        len_f = hdr_at(fill_reg, hdr_reg[efd_pkg::IDX_LEN], efd_pkg::IDX_LEN);
        len_n = (len_f > efd_pkg::LEN_BIAS) ? len_f - efd_pkg::LEN_BIAS : 8'h00;
        avail = (fill_reg > FW'(efd_pkg::HDR_LEN)) ? fill_reg - FW'(efd_pkg::HDR_LEN) : '0;
        n_next = (len_n > 8'(avail)) ? avail : FW'(len_n);
    end

    assign ram_raddr = AW'(k_reg + FW'(efd_pkg::HDR_LEN));

    efd_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (store),
        .waddr (fill_reg[AW-1:0]),
        .wdata (store_val),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            esc_reg       <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            esc_reg  <= esc_next;
            if (cmd.begin_emit)
            begin
                k_reg <= '0;
            end
            else if (cmd.load_data)
            begin
                k_reg <= k_reg + FW'(1);
            end
            if (cmd.load_empty || cmd.load_data)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            for (int i = efd_pkg::IDX_LEN; i <= efd_pkg::IDX_ADHI; i++)
            begin
                if (fill_reg == FW'(i))
                begin
                    hdr_reg[i] <= store_val;
                end
            end
        end
        // run copies, the output register may still hold a result of the last frame
        if (cmd.begin_emit)
        begin
            n_reg        <= n_next;
            run_src_reg  <= hdr_at(fill_reg, hdr_reg[efd_pkg::IDX_SRC], efd_pkg::IDX_SRC);
            run_dst_reg  <= hdr_at(fill_reg, hdr_reg[efd_pkg::IDX_DST], efd_pkg::IDX_DST);
            run_addr_reg <= {hdr_at(fill_reg, hdr_reg[efd_pkg::IDX_ADHI], efd_pkg::IDX_ADHI),
                             hdr_at(fill_reg, hdr_reg[efd_pkg::IDX_ADLO], efd_pkg::IDX_ADLO)};
        end
        if (cmd.load_empty)
        begin
            src_reg  <= run_src_reg;
            dst_reg  <= run_dst_reg;
            addr_reg <= run_addr_reg;
            pay_reg  <= 8'h00;
            pv_reg   <= 1'b0;
            last_reg <= 1'b1;
        end
        else if (cmd.load_data)
        begin
            src_reg  <= run_src_reg;
            dst_reg  <= run_dst_reg;
            addr_reg <= run_addr_reg;
            pay_reg  <= ram_rdata;
            pv_reg   <= 1'b1;
            last_reg <= status.run_last;
        end
    end

    always_comb
    begin
        status.is_start  = (rx_byte == efd_pkg::START_BYTE);
        status.is_end    = (rx_byte == efd_pkg::END_BYTE);
        status.buf_full  = (fill_reg >= FW'(BUF_DEPTH));
        status.run_empty = (n_next == '0);
        status.out_free  = !out_valid_reg || out_ready;
        status.run_last  = (k_reg + FW'(1) == n_reg);
    end

    assign out_valid     = out_valid_reg;
    assign src_port      = src_reg;
    assign dst_port      = dst_reg;
    assign node_addr     = addr_reg;
    assign payload_byte  = pay_reg;
    assign payload_valid = pv_reg;
    assign last          = last_reg;

endmodule

/* rtl/core/efd_ctrl.sv */
`timescale 1ns / 1ps

module efd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  efd_pkg::status_t status,
    output efd_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_RECV,
        ST_EMPTY,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_HUNT) || (state_reg == ST_RECV);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (accept && status.is_start)
                begin
                    state_next = ST_RECV;
                end
            end
            ST_RECV:
            begin
                if (accept)
                begin
                    if (status.buf_full)
                    begin
                        cmd.drop_frame = 1'b1;
                        state_next     = ST_HUNT;
                    end
                    else if (status.is_end)
                    begin
                        cmd.begin_emit = 1'b1;
                        cmd.drop_frame = 1'b1;
                        state_next     = status.run_empty ? ST_EMPTY : ST_READ;
                    end
                    else
                    begin
                        cmd.take_byte = 1'b1;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.load_empty = 1'b1;
                    state_next     = ST_HUNT;
                end
            end
            // ram read is in flight in this state
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_data = 1'b1;
                    state_next    = status.run_last ? ST_HUNT : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0]  src_port;
    logic [7:0]  dst_port;
    logic [15:0] node_addr;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        last;
} frame_result_t;

// tracks the deframer state byte by byte and holds the payload results still due
class frame_checker;
    localparam int DEPTH = efd_pkg::DEF_BUF_DEPTH;

    bit            in_frame;
    bit            esc_pending;
    int            fill;
    logic [7:0]    frame_mem [DEPTH];
    frame_result_t due_results [$];
    int            errors;
    int            live_bytes;

    function void drop_frame();
        in_frame    = 1'b0;
        esc_pending = 1'b0;
        fill        = 0;
    endfunction

    function void store_byte(logic [7:0] v);
        if (fill < DEPTH)
        begin
            frame_mem[fill] = v;
            fill++;
        end
    endfunction

    function logic [7:0] hdr_byte(int idx);
        return (idx < fill) ? frame_mem[idx] : 8'h00;
    endfunction

    function void unload_frame();
        frame_result_t r;
        int avail;
        int run_len;
        r.src_port     = hdr_byte(efd_pkg::IDX_SRC);
        r.dst_port     = hdr_byte(efd_pkg::IDX_DST);
        r.node_addr    = {hdr_byte(efd_pkg::IDX_ADHI), hdr_byte(efd_pkg::IDX_ADLO)};
        avail          = (fill > efd_pkg::HDR_LEN) ? fill - efd_pkg::HDR_LEN : 0;
        run_len        = (hdr_byte(efd_pkg::IDX_LEN) > efd_pkg::LEN_BIAS) ?
                         hdr_byte(efd_pkg::IDX_LEN) - efd_pkg::LEN_BIAS : 0;
        if (run_len > avail)
            run_len = avail;
        if (run_len == 0)
        begin
            r.payload_byte  = 8'h00;
            r.payload_valid = 1'b0;
            r.last          = 1'b1;
            due_results.push_back(r);
        end
        for (int k = 0; k < run_len; k++)
        begin
            r.payload_byte  = frame_mem[efd_pkg::HDR_LEN + k];
            r.payload_valid = 1'b1;
            r.last          = (k + 1 == run_len);
            due_results.push_back(r);
        end
    endfunction

    function void take_rx_byte(logic [7:0] b);
        if (!in_frame)
        begin
            if (b == efd_pkg::START_BYTE)
            begin
                in_frame = 1'b1;
                live_bytes++;
            end
            return;
        end
        live_bytes++;
        // full buffer: whatever comes next kills the frame
        if (fill >= DEPTH)
        begin
            drop_frame();
            return;
        end
        case (b)
            efd_pkg::ESC_FE:
            begin
                store_byte(esc_pending ? efd_pkg::START_BYTE : efd_pkg::ESC_FE);
                esc_pending = 1'b0;
            end
            efd_pkg::ESC_FF:
            begin
                store_byte(esc_pending ? efd_pkg::END_BYTE : efd_pkg::ESC_FF);
                esc_pending = 1'b0;
            end
            efd_pkg::START_BYTE:
                esc_pending = 1'b1;
            efd_pkg::END_BYTE:
            begin
                unload_frame();
                drop_frame();
            end
            default:
                store_byte(b);
        endcase
    endfunction

    function void match_output(frame_result_t got);
        frame_result_t want;
        if (due_results.size() == 0)
        begin
            $error("result with no frame pending, payload_byte %0h", got.payload_byte);
            errors++;
            return;
        end
        want = due_results.pop_front();
        if (got.src_port !== want.src_port)
        begin
            $error("src_port expected %0h actual %0h", want.src_port, got.src_port);
            errors++;
        end
        if (got.dst_port !== want.dst_port)
        begin
            $error("dst_port expected %0h actual %0h", want.dst_port, got.dst_port);
            errors++;
        end
        if (got.node_addr !== want.node_addr)
        begin
            $error("node_addr expected %0h actual %0h", want.node_addr, got.node_addr);
            errors++;
        end
        if (got.payload_byte !== want.payload_byte)
        begin
            $error("payload_byte expected %0h actual %0h", want.payload_byte,
                   got.payload_byte);
            errors++;
        end
        if (got.payload_valid !== want.payload_valid)
        begin
            $error("payload_valid expected %0b actual %0b", want.payload_valid,
                   got.payload_valid);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last expected %0b actual %0b", want.last, got.last);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int RX_HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    bit   calm;
    bit   hold_rx;

    frame_checker chk = new();

    efd_in_if  rx_ch ();
    efd_out_if res_ch ();

    escaped_frame_deframer_top #(
        .BUF_DEPTH(efd_pkg::DEF_BUF_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .rx(rx_ch),
        .res(res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("escaped_frame_deframer_top: mismatch");
        $finish;
    end

    function automatic int draw_gap();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // bias toward the four marker values
    function automatic logic [7:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return 8'(efd_pkg::ESC_FE + $urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        chk.take_rx_byte(b);
        @(negedge clk);
    endtask

    task automatic send_value(input logic [7:0] v);
        if (v == efd_pkg::START_BYTE)
        begin
            send_byte(efd_pkg::START_BYTE);
            send_byte(efd_pkg::ESC_FE);
        end
        else if (v == efd_pkg::END_BYTE)
        begin
            send_byte(efd_pkg::START_BYTE);
            send_byte(efd_pkg::ESC_FF);
        end
        else
        begin
            // stray escape ahead of a plain byte stays pending
            if (v != efd_pkg::ESC_FE && v != efd_pkg::ESC_FF && $urandom_range(0, 15) == 0)
                send_byte(efd_pkg::START_BYTE);
            send_byte(v);
        end
    endtask

    task automatic send_frame(input int npay, input int len_field, input int n_hdr,
                              input bit closed);
        logic [7:0] hdr [6];
        for (int i = 0; i < 6; i++)
            hdr[i] = pick_value();
        hdr[efd_pkg::IDX_LEN] = 8'(len_field);
        send_byte(efd_pkg::START_BYTE);
        for (int i = 0; i < n_hdr; i++)
            send_value(hdr[i]);
        if (n_hdr == efd_pkg::HDR_LEN)
            for (int i = 0; i < npay; i++)
                send_value(pick_value());
        if (closed)
            send_byte(efd_pkg::END_BYTE);
    endtask

    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        do @(negedge clk); while (chk.due_results.size() != 0);
    endtask

    task automatic send_random_frame();
        int npay;
        int len_field;
        npay      = ($urandom_range(0, 9) == 0) ? 57 : $urandom_range(0, 12);
        len_field = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : npay + 4;
        send_frame(npay, len_field, efd_pkg::HDR_LEN, 1'b1);
    endtask

    // result side
    initial
    begin
        frame_result_t got;
        bit taken;
        int gap;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (hold_rx)
            begin
                res_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                hold_rx = 1'b0;
                gap = 0;
            end
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            taken = 1'b0;
            do
            begin
                @(posedge clk);
                if (res_ch.valid)
                begin
                    got.src_port      = res_ch.src_port;
                    got.dst_port      = res_ch.dst_port;
                    got.node_addr     = res_ch.node_addr;
                    got.payload_byte  = res_ch.payload_byte;
                    got.payload_valid = res_ch.payload_valid;
                    got.last          = res_ch.last;
                    chk.match_output(got);
                    taken = 1'b1;
                end
            end
            while (!taken && !hold_rx);
            @(negedge clk);
        end
    end

    // request side
    initial
    begin
        int pick;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        calm          = 1'b0;
        hold_rx       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // noise while hunting
        send_byte(8'h00);
        send_byte(efd_pkg::END_BYTE);
        // length byte never received: empty result, zero header
        send_byte(efd_pkg::START_BYTE);
        send_byte(8'h00);
        send_byte(efd_pkg::END_BYTE);
        // escaped and literal markers, repeated escape, escape before a plain byte
        send_byte(efd_pkg::START_BYTE);
        send_byte(8'h00);
        send_byte(8'h05);
        send_byte(efd_pkg::START_BYTE);
        send_byte(efd_pkg::ESC_FE);
        send_byte(efd_pkg::START_BYTE);
        send_byte(efd_pkg::START_BYTE);
        send_byte(efd_pkg::ESC_FF);
        send_byte(efd_pkg::ESC_FE);
        send_byte(efd_pkg::ESC_FF);
        send_byte(efd_pkg::START_BYTE);
        send_byte(8'h41);
        send_byte(efd_pkg::ESC_FE);
        send_byte(efd_pkg::END_BYTE);
        // length field exactly four: empty frame
        send_byte(efd_pkg::START_BYTE);
        for (int i = 0; i < 6; i++)
            send_byte(i == efd_pkg::IDX_LEN ? efd_pkg::LEN_BIAS : 8'h00);
        send_byte(efd_pkg::END_BYTE);
        wait_drained();

        // back up the output while requests keep coming
        calm    = 1'b1;
        hold_rx = 1'b1;
        repeat (3) send_frame(12, 16, efd_pkg::HDR_LEN, 1'b1);
        calm = 1'b0;
        wait_drained();

        while (chk.live_bytes < 330)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = ~calm;
            pick = $urandom_range(0, 99);
            if (pick < 66)
                send_random_frame();
            else if (pick < 72)
                send_byte(8'($urandom_range(0, 253)));
            else if (pick < 80)
                send_frame(0, $urandom_range(0, 255), $urandom_range(0, 5),
                           $urandom_range(0, 3) != 0);
            else if (pick < 85)
            begin
                // fill the buffer, then one more byte of any value
                send_byte(efd_pkg::START_BYTE);
                repeat (efd_pkg::DEF_BUF_DEPTH) send_byte(8'($urandom_range(0, 251)));
                send_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 95)
            begin
                send_byte(efd_pkg::START_BYTE);
                repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(0, 255)));
                send_byte(efd_pkg::END_BYTE);
            end
            else
                wait_drained();
        end
        rx_ch.valid <= 1'b0;

        while (chk.due_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (chk.errors == 0 && chk.due_results.size() == 0)
            $display("escaped_frame_deframer_top: match");
        else
            $display("escaped_frame_deframer_top: mismatch");
        $finish;
    end
endmodule
